// ----- hw/rtl/session_nonce_packet_dispatcher_assert.svh -----
// assertion macros for the session nonce packet dispatcher checker
`ifndef SESSION_NONCE_PACKET_DISPATCHER_ASSERT_SVH
`define SESSION_NONCE_PACKET_DISPATCHER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SNPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define SNPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/snpd_pkg.sv -----
// shared types, codes and sizes of the session nonce packet dispatcher
`default_nettype none

package snpd_pkg;

  localparam int unsigned SESSION_SLOTS  = 8;
  localparam int unsigned ENDPOINT_COUNT = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SESSION_SLOTS + 1);

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned NONCE_W = 32;
  localparam int unsigned EP_W    = 4;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_DISCOVERY = 3'd0,
    CMD_PING      = 3'd1,
    CMD_GET       = 3'd2,
    CMD_SEND      = 3'd3,
    CMD_POST      = 3'd4,
    CMD_ACK       = 3'd5,
    CMD_GET_RESP  = 3'd6,
    CMD_UNKNOWN   = 3'd7
  } snpd_cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_ECHO       = 3'd0,
    ACT_DISC_REPLY = 3'd1,
    ACT_GET        = 3'd2,
    ACT_SEND       = 3'd3,
    ACT_POST       = 3'd4,
    ACT_ACK        = 3'd5,
    ACT_NOT_FOUND  = 3'd6,
    ACT_UNKNOWN    = 3'd7
  } snpd_action_e;

  typedef enum logic [2:0] {
    OP_ECHO,
    OP_DISC,
    OP_GET,
    OP_SEND,
    OP_POST,
    OP_UNKNOWN
  } snpd_op_e;

  typedef enum logic [1:0] {
    REG_DISCOVERY_READY = 2'd0,
    REG_GET_MASK        = 2'd1,
    REG_SEND_MASK       = 2'd2,
    REG_POST_MASK       = 2'd3
  } snpd_reg_e;

  typedef struct packed {
    snpd_op_e           op;
    logic [KEY_W-1:0]   key;
    logic [NONCE_W-1:0] nonce;
    logic [EP_W-1:0]    ep;
    logic               ep_ok;
  } snpd_item_t;

  typedef struct packed {
    logic               valid;
    snpd_action_e       action;
    logic [KEY_W-1:0]   session;
    logic [NONCE_W-1:0] nonce;
    logic [EP_W-1:0]    endpoint;
    logic               last;
  } snpd_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/snpd_front.sv -----
// front end: config registers, request classification and endpoint check
`default_nettype none

module snpd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        full_i,
  input  logic [snpd_pkg::CMD_W-1:0]  command_i,
  input  logic [snpd_pkg::KEY_W-1:0]  session_key_i,
  input  logic [snpd_pkg::NONCE_W-1:0] packet_nonce_i,
  input  logic [snpd_pkg::EP_W-1:0]   endpoint_id_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [snpd_pkg::APB_AW-1:0] paddr_i,
  input  logic [snpd_pkg::APB_DW-1:0] pwdata_i,
  output logic [snpd_pkg::APB_DW-1:0] prdata_o,
  output logic                        busy_o,
  output logic                        push_o,
  output snpd_pkg::snpd_item_t        item_o
);
  import snpd_pkg::*;

  logic              discovery_ready_q;
  logic [MASK_W-1:0] get_mask_q;
  logic [MASK_W-1:0] send_mask_q;
  logic [MASK_W-1:0] post_mask_q;

  logic      cfg_wr;
  snpd_reg_e cfg_idx;
  logic      accept;
  logic      ep_in_range;
  logic      keep;

  assign cfg_wr  = psel_i && penable_i && pwrite_i;
  assign cfg_idx = snpd_reg_e'(paddr_i[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discovery_ready_q <= 1'b0;
      get_mask_q        <= '0;
      send_mask_q       <= '0;
      post_mask_q       <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DISCOVERY_READY: discovery_ready_q <= pwdata_i[0];
        REG_GET_MASK:        get_mask_q        <= pwdata_i[MASK_W-1:0];
        REG_SEND_MASK:       send_mask_q       <= pwdata_i[MASK_W-1:0];
        REG_POST_MASK:       post_mask_q       <= pwdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DISCOVERY_READY: prdata_o = APB_DW'(discovery_ready_q);
      REG_GET_MASK:        prdata_o = APB_DW'(get_mask_q);
      REG_SEND_MASK:       prdata_o = APB_DW'(send_mask_q);
      REG_POST_MASK:       prdata_o = APB_DW'(post_mask_q);
      default:             prdata_o = '0;
    endcase
  end

  assign busy_o      = full_i;
  assign accept      = start_i && !full_i;
  assign ep_in_range = 32'(endpoint_id_i) < 32'(ENDPOINT_COUNT);

  // ack and get response, and discovery without a response, are dropped here
  always_comb begin
    item_o.key   = session_key_i;
    item_o.nonce = packet_nonce_i;
    item_o.ep    = endpoint_id_i;
    item_o.ep_ok = 1'b0;
    item_o.op    = OP_UNKNOWN;
    keep         = 1'b1;
    case (snpd_cmd_e'(command_i))
      CMD_DISCOVERY: begin
        item_o.op = OP_DISC;
        keep      = discovery_ready_q;
      end
      CMD_PING: item_o.op = OP_ECHO;
      CMD_GET: begin
        item_o.op    = OP_GET;
        item_o.ep_ok = ep_in_range && get_mask_q[endpoint_id_i];
      end
      CMD_SEND: begin
        item_o.op    = OP_SEND;
        item_o.ep_ok = ep_in_range && send_mask_q[endpoint_id_i];
      end
      CMD_POST: begin
        item_o.op    = OP_POST;
        item_o.ep_ok = ep_in_range && post_mask_q[endpoint_id_i];
      end
      CMD_UNKNOWN: item_o.op = OP_UNKNOWN;
      default: keep = 1'b0;
    endcase
  end

  assign push_o = accept && keep;

endmodule

`default_nettype wire

// ----- hw/rtl/snpd_fifo.sv -----
// short request queue between front end and back end
`default_nettype none

module snpd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  snpd_pkg::snpd_item_t item_i,
  input  logic                 pop_i,
  output snpd_pkg::snpd_item_t item_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import snpd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  snpd_item_t        entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q;
  logic [PTR_W-1:0]  rptr_q;
  logic [QCNT_W-1:0] count_q;

  logic do_push;
  logic do_pop;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = entry_q[rptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= ptr_next(rptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/snpd_back.sv -----
// back end: session table, nonce check and result sequencing
`default_nettype none

module snpd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  snpd_pkg::snpd_item_t   item_i,
  output logic                   pop_o,
  output snpd_pkg::snpd_result_t res_o
);
  import snpd_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_SECOND
  } state_e;

  state_e             state_q;
  snpd_item_t         cur_q;
  snpd_result_t       res_q;
  snpd_action_e       second_q;
  logic [SESSION_SLOTS-1:0] slot_valid_q;
  logic [KEY_W-1:0]   slot_session_q [SESSION_SLOTS];
  logic [NONCE_W-1:0] nonce_mem [SESSION_SLOTS];
  logic [NONCE_W-1:0] nonce_rd_q;
  logic [SLOT_W-1:0]  oldest_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [CNT_W-1:0]   used_q;
  logic               miss_q;

  logic [SESSION_SLOTS-1:0] hit_vec;
  logic               hit_any;
  logic [SLOT_W-1:0]  hit_idx;
  logic [SUM_W-1:0]   ins_sum;
  logic [SLOT_W-1:0]  ins_pos;
  logic [SLOT_W-1:0]  look_slot;
  logic [NONCE_W-1:0] stored;
  logic               fresh;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_addr;
  logic [NONCE_W-1:0] mem_wdata;

  function automatic snpd_result_t mk_result(snpd_action_e act, snpd_item_t it, logic lst);
    snpd_result_t r;
    r.valid    = 1'b1;
    r.action   = act;
    r.session  = it.key;
    r.nonce    = it.nonce;
    r.endpoint = it.ep;
    r.last     = lst;
    return r;
  endfunction

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign res_o = res_q;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SESSION_SLOTS; i++) begin
      hit_vec[i] = slot_valid_q[i] && (slot_session_q[i] == cur_q.key);
    end
    for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
    hit_any = |hit_vec;
  end

  // ring insert position, also the oldest slot when the table is full
  assign ins_sum = SUM_W'(oldest_q) + SUM_W'(used_q);
  assign ins_pos = (ins_sum >= SUM_W'(SESSION_SLOTS)) ? SLOT_W'(ins_sum - SUM_W'(SESSION_SLOTS))
                                                     : SLOT_W'(ins_sum);
  assign look_slot = hit_any ? hit_idx : ins_pos;

  assign stored = miss_q ? '0 : nonce_rd_q;
  assign fresh  = cur_q.nonce > stored;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = slot_q;
    mem_wdata = cur_q.nonce;
    if ((state_q == S_LOOK) && !hit_any) begin
      mem_we    = 1'b1;
      mem_addr  = ins_pos;
      mem_wdata = '0;
    end else if ((state_q == S_EVAL) && fresh &&
                 ((cur_q.op == OP_SEND) || (cur_q.op == OP_POST))) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      nonce_mem[mem_addr] <= mem_wdata;
    end
    if (state_q == S_LOOK) begin
      nonce_rd_q <= nonce_mem[look_slot];
    end
    if ((state_q == S_LOOK) && !hit_any) begin
      slot_session_q[ins_pos] <= cur_q.key;
    end
    if (pop_o) begin
      cur_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_q        <= '0;
      second_q     <= ACT_ACK;
      slot_valid_q <= '0;
      oldest_q     <= '0;
      used_q       <= '0;
      slot_q       <= '0;
      miss_q       <= 1'b0;
    end else begin
      res_q.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            case (item_i.op)
              OP_GET, OP_SEND, OP_POST: state_q <= S_LOOK;
              OP_DISC: res_q <= mk_result(ACT_DISC_REPLY, item_i, 1'b1);
              OP_ECHO: res_q <= mk_result(ACT_ECHO, item_i, 1'b1);
              default: res_q <= mk_result(ACT_UNKNOWN, item_i, 1'b1);
            endcase
          end
        end
        S_LOOK: begin
          slot_q  <= look_slot;
          miss_q  <= !hit_any;
          state_q <= S_EVAL;
          if (!hit_any) begin
            slot_valid_q[ins_pos] <= 1'b1;
            if (used_q == CNT_W'(SESSION_SLOTS)) begin
              oldest_q <= (oldest_q == SLOT_W'(SESSION_SLOTS - 1)) ? '0
                                                                  : oldest_q + SLOT_W'(1);
            end else begin
              used_q <= used_q + CNT_W'(1);
            end
          end
        end
        S_EVAL: begin
          state_q <= S_IDLE;
          case (cur_q.op)
            OP_GET: begin
              res_q <= mk_result(cur_q.ep_ok ? ACT_GET : ACT_NOT_FOUND, cur_q, 1'b1);
            end
            OP_SEND: begin
              if (fresh) begin
                res_q <= mk_result(cur_q.ep_ok ? ACT_SEND : ACT_NOT_FOUND, cur_q, 1'b1);
              end
            end
            OP_POST: begin
              if (fresh) begin
                res_q    <= mk_result(cur_q.ep_ok ? ACT_POST : ACT_ACK, cur_q, 1'b0);
                second_q <= cur_q.ep_ok ? ACT_ACK : ACT_NOT_FOUND;
                state_q  <= S_SECOND;
              end else begin
                res_q <= mk_result(ACT_ACK, cur_q, 1'b1);
              end
            end
            default: ;
          endcase
        end
        S_SECOND: begin
          res_q   <= mk_result(second_q, cur_q, 1'b1);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/session_nonce_packet_dispatcher.sv -----
// top level of the session nonce packet dispatcher
// accepted requests pass the queue; echo, discovery, unknown results register on the pop,
// get, send, post results after the lookup and evaluate states, a second post result in the
// cycle after; one echo/discovery/unknown request per cycle while idle, and a table request
// (take, lookup, evaluate) ends before the next; busy while queue full, no output stall
// reset: asynchronous active low, clears registers, queue, table valid bits and ring
`default_nettype none

module session_nonce_packet_dispatcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [snpd_pkg::CMD_W-1:0]  command_i,
  input  logic [snpd_pkg::KEY_W-1:0]  session_key_i,
  input  logic [snpd_pkg::NONCE_W-1:0] packet_nonce_i,
  input  logic [snpd_pkg::EP_W-1:0]   endpoint_id_i,
  output logic                        result_valid_o,
  output logic [snpd_pkg::ACT_W-1:0]  action_o,
  output logic [snpd_pkg::KEY_W-1:0]  reply_session_o,
  output logic [snpd_pkg::NONCE_W-1:0] reply_nonce_o,
  output logic [snpd_pkg::EP_W-1:0]   reply_endpoint_o,
  output logic                        last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [snpd_pkg::APB_AW-1:0] paddr,
  input  logic [snpd_pkg::APB_DW-1:0] pwdata,
  output logic [snpd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import snpd_pkg::*;

  logic         push;
  logic         pop;
  logic         full;
  logic         empty;
  snpd_item_t   front_item;
  snpd_item_t   head_item;
  snpd_result_t res;

  assign pready = 1'b1;

  snpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .full_i         (full),
    .command_i      (command_i),
    .session_key_i  (session_key_i),
    .packet_nonce_i (packet_nonce_i),
    .endpoint_id_i  (endpoint_id_i),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .busy_o         (busy),
    .push_o         (push),
    .item_o         (front_item)
  );

  snpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  snpd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .res_o   (res)
  );

  assign result_valid_o   = res.valid;
  assign action_o         = res.action;
  assign reply_session_o  = res.session;
  assign reply_nonce_o    = res.nonce;
  assign reply_endpoint_o = res.endpoint;
  assign last_o           = res.last;

endmodule

`default_nettype wire

// ----- hw/rtl/snpd_checker.sv -----
// port-level assertions for the session nonce packet dispatcher, with bind
`default_nettype none

`include "session_nonce_packet_dispatcher_assert.svh"

module snpd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         result_valid_o,
  input logic [snpd_pkg::ACT_W-1:0]   action_o,
  input logic [snpd_pkg::KEY_W-1:0]   reply_session_o,
  input logic [snpd_pkg::NONCE_W-1:0] reply_nonce_o,
  input logic [snpd_pkg::EP_W-1:0]    reply_endpoint_o,
  input logic                         last_o
);
  import snpd_pkg::*;

  logic                            pair_open;
  logic                            first_ok;
  logic                            second_ok;
  logic [KEY_W+NONCE_W+EP_W-1:0]   reply_tag;

  assign pair_open = result_valid_o && !last_o;
  assign first_ok  = (action_o == ACT_POST) || (action_o == ACT_ACK);
  assign second_ok = (action_o == ACT_ACK) || (action_o == ACT_NOT_FOUND);
  assign reply_tag = {reply_session_o, reply_nonce_o, reply_endpoint_o};

  // a non-final result is always followed at once by the final one
  `SNPD_ASSERT_NEXT(a_pair_follows, pair_open, result_valid_o && last_o, "second result missing")

  // both results of a pair concern the same request
  `SNPD_ASSERT_NEXT(a_pair_same_req, pair_open, $stable(reply_tag), "pair fields differ")

  // the first result of a pair is a post or an ack, as only a fresh post opens a pair
  `SNPD_ASSERT_NOW(a_pair_first_act, pair_open, first_ok, "bad first action of pair")

  `SNPD_ASSERT_NEXT(a_pair_second_act, pair_open, second_ok, "bad second action of pair")

endmodule

bind session_nonce_packet_dispatcher snpd_checker u_snpd_checker (.*);

`default_nettype wire

// ----- tb/session_nonce_packet_dispatcher_tb.sv -----
// testbench for the session nonce packet dispatcher with a session table scoreboard
`default_nettype none

module session_nonce_packet_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import snpd_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 440;
  localparam int KEY_POOL_SIZE = 12;

  typedef struct {
    snpd_action_e       act;
    logic [KEY_W-1:0]   session;
    logic [NONCE_W-1:0] nonce;
    logic [EP_W-1:0]    ep;
    logic               last;
  } action_rec_t;

  class session_table_model;
    logic [KEY_W-1:0]   slot_key [SESSION_SLOTS];
    logic [NONCE_W-1:0] slot_seq [SESSION_SLOTS];
    bit                 slot_used [SESSION_SLOTS];
    int unsigned        head;
    int unsigned        fill;
    bit                 disc_on;
    logic [MASK_W-1:0]  get_mask;
    logic [MASK_W-1:0]  send_mask;
    logic [MASK_W-1:0]  post_mask;
    action_rec_t        expected_actions [$];
    int                 mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      head = 0;
      fill = 0;
      disc_on = 1'b0;
      get_mask = '0;
      send_mask = '0;
      post_mask = '0;
      mismatches = 0;
    endfunction

    function void set_register(snpd_reg_e idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_DISCOVERY_READY: disc_on = value[0];
        REG_GET_MASK:        get_mask = value[MASK_W-1:0];
        REG_SEND_MASK:       send_mask = value[MASK_W-1:0];
        REG_POST_MASK:       post_mask = value[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned lookup_or_insert(logic [KEY_W-1:0] key);
      int unsigned pos;
      for (int i = 0; i < SESSION_SLOTS; i++) begin
        if (slot_used[i] && slot_key[i] == key) return i;
      end
      if (fill < SESSION_SLOTS) begin
        pos = (head + fill) % SESSION_SLOTS;
        fill++;
      end else begin
        pos = head;
        head = (head + 1) % SESSION_SLOTS;
      end
      slot_key[pos] = key;
      slot_seq[pos] = '0;
      slot_used[pos] = 1'b1;
      return pos;
    endfunction

    function bit ep_registered(logic [MASK_W-1:0] mask, logic [EP_W-1:0] ep);
      if (int'(ep) >= ENDPOINT_COUNT) return 1'b0;
      return mask[ep];
    endfunction

    function void take_header(snpd_cmd_e cmd, logic [KEY_W-1:0] key,
                              logic [NONCE_W-1:0] nonce, logic [EP_W-1:0] ep);
      snpd_action_e acts [$];
      int unsigned s;
      action_rec_t rec;
      case (cmd)
        CMD_DISCOVERY: if (disc_on) acts.insert(acts.size(), ACT_DISC_REPLY);
        CMD_PING:      acts.insert(acts.size(), ACT_ECHO);
        CMD_GET: begin
          s = lookup_or_insert(key);
          acts.insert(acts.size(), ep_registered(get_mask, ep) ? ACT_GET : ACT_NOT_FOUND);
        end
        CMD_SEND: begin
          s = lookup_or_insert(key);
          if (nonce > slot_seq[s]) begin
            slot_seq[s] = nonce;
            acts.insert(acts.size(), ep_registered(send_mask, ep) ? ACT_SEND : ACT_NOT_FOUND);
          end
        end
        CMD_POST: begin
          s = lookup_or_insert(key);
          if (nonce > slot_seq[s]) begin
            slot_seq[s] = nonce;
            if (ep_registered(post_mask, ep)) begin
              acts.insert(acts.size(), ACT_POST);
              acts.insert(acts.size(), ACT_ACK);
            end else begin
              acts.insert(acts.size(), ACT_ACK);
              acts.insert(acts.size(), ACT_NOT_FOUND);
            end
          end else begin
            acts.insert(acts.size(), ACT_ACK);
          end
        end
        CMD_UNKNOWN:   acts.insert(acts.size(), ACT_UNKNOWN);
        default: ;
      endcase
      foreach (acts[i]) begin
        rec.act = acts[i];
        rec.session = key;
        rec.nonce = nonce;
        rec.ep = ep;
        rec.last = (i == acts.size() - 1);
        expected_actions.insert(expected_actions.size(), rec);
      end
    endfunction

    function void match_action(logic [ACT_W-1:0] act, logic [KEY_W-1:0] session,
                               logic [NONCE_W-1:0] nonce, logic [EP_W-1:0] ep,
                               logic last);
      action_rec_t want;
      if (expected_actions.size() == 0) begin
        $error("unexpected action %0d session %h nonce %h", act, session, nonce);
        mismatches++;
        return;
      end
      want = expected_actions[0];
      expected_actions.delete(0);
      if (act !== want.act) begin
        $error("action expected %0d got %0d", want.act, act);
        mismatches++;
      end
      if (session !== want.session) begin
        $error("reply_session expected %h got %h", want.session, session);
        mismatches++;
      end
      if (nonce !== want.nonce) begin
        $error("reply_nonce expected %h got %h", want.nonce, nonce);
        mismatches++;
      end
      if (ep !== want.ep) begin
        $error("reply_endpoint expected %0d got %0d", want.ep, ep);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last expected %0b got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command_i = '0;
  logic [KEY_W-1:0] session_key_i = '0;
  logic [NONCE_W-1:0] packet_nonce_i = '0;
  logic [EP_W-1:0] endpoint_id_i = '0;
  logic result_valid_o;
  logic [ACT_W-1:0] action_o;
  logic [KEY_W-1:0] reply_session_o;
  logic [NONCE_W-1:0] reply_nonce_o;
  logic [EP_W-1:0] reply_endpoint_o;
  logic last_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  session_table_model sb = new();
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
  bit [NONCE_W-1:0] newest_nonce [bit [KEY_W-1:0]];
  int idle_pct [4] = '{0, 59, 0, 32};

  session_nonce_packet_dispatcher i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .session_key_i    (session_key_i),
    .packet_nonce_i   (packet_nonce_i),
    .endpoint_id_i    (endpoint_id_i),
    .result_valid_o   (result_valid_o),
    .action_o         (action_o),
    .reply_session_o  (reply_session_o),
    .reply_nonce_o    (reply_nonce_o),
    .reply_endpoint_o (reply_endpoint_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.match_action(action_o, reply_session_o, reply_nonce_o, reply_endpoint_o, last_o);
    end
  end

  task automatic write_register(input snpd_reg_e idx, input logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic configure(input logic ready, input logic [MASK_W-1:0] get_m,
                           input logic [MASK_W-1:0] send_m, input logic [MASK_W-1:0] post_m);
    write_register(REG_DISCOVERY_READY, APB_DW'(ready));
    write_register(REG_GET_MASK, APB_DW'(get_m));
    write_register(REG_SEND_MASK, APB_DW'(send_m));
    write_register(REG_POST_MASK, APB_DW'(post_m));
  endtask

  // request stays on the bus until the block takes it
  task automatic drive_header(input snpd_cmd_e cmd, input logic [KEY_W-1:0] key,
                              input logic [NONCE_W-1:0] nonce, input logic [EP_W-1:0] ep,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    session_key_i <= key;
    packet_nonce_i <= nonce;
    endpoint_id_i <= ep;
    do @(posedge clk_i); while (busy);
    sb.take_header(cmd, key, nonce, ep);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_actions.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_gap(int pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  function automatic snpd_cmd_e pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 20) return CMD_GET;
    if (r < 45) return CMD_SEND;
    if (r < 70) return CMD_POST;
    if (r < 77) return CMD_PING;
    if (r < 84) return CMD_DISCOVERY;
    if (r < 90) return CMD_UNKNOWN;
    if (r < 95) return CMD_ACK;
    return CMD_GET_RESP;
  endfunction

  // nonces cluster around the newest one seen per session so fresh and stale both occur
  function automatic logic [NONCE_W-1:0] pick_nonce(logic [KEY_W-1:0] key);
    bit [NONCE_W-1:0] seen;
    int r;
    seen = newest_nonce.exists(key) ? newest_nonce[key] : '0;
    r = $urandom_range(99);
    if (r < 40) return seen + $urandom_range(1, 3);
    if (r < 55) return seen;
    if (r < 70) return seen - $urandom_range(1, 5);
    if (r < 85) return $urandom_range(30);
    if (r < 95) return $urandom;
    return ($urandom_range(1) != 0) ? '1 : '0;
  endfunction

  task automatic random_phase(input int pct);
    snpd_cmd_e cmd;
    logic [KEY_W-1:0] key;
    logic [NONCE_W-1:0] nonce;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      cmd = pick_cmd();
      key = ($urandom_range(9) != 0) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)] : $urandom;
      nonce = pick_nonce(key);
      if (!newest_nonce.exists(key) || nonce > newest_nonce[key]) newest_nonce[key] = nonce;
      drive_header(cmd, key, nonce, EP_W'($urandom_range(15)), pick_gap(pct));
    end
    drain();
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset values
    drive_header(CMD_DISCOVERY, 32'h1234_5678, 32'h9, 4'd1, 0);
    drive_header(CMD_PING, '1, '1, 4'd15, 0);
    drive_header(CMD_ACK, 32'h1, 32'h1, 4'd2, 0);
    drive_header(CMD_GET_RESP, 32'h1, 32'h2, 4'd2, 0);
    drive_header(CMD_UNKNOWN, '0, '0, 4'd0, 0);
    drive_header(CMD_GET, 32'h1, 32'h7, 4'd3, 0);
    drive_header(CMD_SEND, 32'h1, 32'h5, 4'd3, 0);
    drive_header(CMD_SEND, 32'h1, 32'h5, 4'd3, 0);
    drive_header(CMD_POST, 32'h2, 32'h1, 4'd4, 0);
    drive_header(CMD_POST, 32'h2, 32'h0, 4'd4, 0);
    drain();

    configure(1'b1, '1, '1, '1);
    drive_header(CMD_DISCOVERY, 32'hA5A5_5A5A, 32'h3, 4'd7, 0);
    drive_header(CMD_GET, 32'h1, 32'h0, 4'd0, 0);
    drive_header(CMD_SEND, '1, '1, 4'd15, 0);
    drive_header(CMD_POST, 32'h3, 32'h9, 4'd8, 0);
    drive_header(CMD_POST, 32'h3, 32'h9, 4'd8, 0);
    // nine new sessions push the oldest ones out of the table
    for (int k = 0; k < 9; k++) drive_header(CMD_GET, 32'd100 + k, 32'h4, 4'd5, 0);
    drive_header(CMD_SEND, 32'h1, 32'h1, 4'd6, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: configure(1'b1, '1, '1, '1);
        1: configure(1'b0, '0, '0, '0);
        2: configure(1'b1, MASK_W'($urandom_range(16'hffff)),
                     MASK_W'($urandom_range(16'hffff)),
                     MASK_W'($urandom_range(16'hffff)));
        default: configure(1'($urandom_range(1)), MASK_W'($urandom_range(16'hffff)),
                           MASK_W'($urandom_range(16'hffff)),
                           MASK_W'($urandom_range(16'hffff)));
      endcase
      random_phase(idle_pct[p]);
    end

    if (sb.expected_actions.size() != 0) begin
      $error("%0d expected actions never arrived", sb.expected_actions.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/snpd_pkg.sv
hw/rtl/snpd_front.sv
hw/rtl/snpd_fifo.sv
hw/rtl/snpd_back.sv
hw/rtl/session_nonce_packet_dispatcher.sv
hw/rtl/snpd_checker.sv
tb/session_nonce_packet_dispatcher_tb.sv
